>>> rtl/core/ctpp_pkg.sv
// Shared types and constants for the tape pulse player.
// No dependencies; imported by every module of the block.
`default_nettype none

package ctpp_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 16;

   localparam logic [9:0] CPS_RESET       = 10'd162;
   localparam logic [7:0] LEVEL_THRESHOLD = 8'd128;

   localparam int HEAD_BYTES = 4;

   typedef logic [1:0] cmd_type;

   localparam cmd_type CMD_RESTART = 2'd0;
   localparam cmd_type CMD_PUSH    = 2'd1;
   localparam cmd_type CMD_READ    = 2'd2;

   typedef struct packed {
      logic       clear;
      logic       push;
      logic [2:0] pop_cnt;
      logic [7:0] wdata;
   } fifo_ctl_type;

   typedef struct packed {
      logic                  full;
      logic [HEAD_BYTES-1:0] avail;   // avail[j]: at least j+1 bytes held
   } fifo_stat_type;

   typedef logic [HEAD_BYTES-1:0][7:0] head_type;

endpackage

`default_nettype wire

>>> rtl/core/csw_tape_pulse_player_top.sv
// Top level of the run-length coded tape pulse player.
// Depends on ctpp_pkg, ctpp_fifo and ctpp_player.
`default_nettype none

// Plays back a run-length coded square-wave tape stream as a one-bit cassette
// level. Every request returns exactly one response, in order. Command 0
// restarts playback and empties the byte FIFO; command 1 pushes a coded byte
// (a full FIFO drops it and flags dropped); command 2 reads one level sample,
// adding cycles_elapsed to the sample clock. A read that needs a byte the
// FIFO does not hold answers level 1 with starved set. The first read after a
// restart takes a polarity byte; each exhausted pulse toggles the level and
// takes a length byte, or a zero byte followed by a 16-bit little-endian
// length. A request is registered on acceptance and resolved, once the
// response register is free or draining, by one pass of decode logic against
// the FIFO's four head bytes; while responses are taken, one request per cycle
// is sustained. Each response is registered in the output register behind
// rsp_valid, which holds a waiting response while the next request is taken.
// csr_wdata sets cycles_per_sample (reset 162) and should be written only
// while the block is idle. FIFO_DEPTH sets the number of buffered bytes (at
// least 4).
module csw_tape_pulse_player_top #(
   parameter int FIFO_DEPTH = ctpp_pkg::FIFO_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_tape_byte,
   input  wire logic [15:0] req_cycles_elapsed,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_level,
   output logic             rsp_starved,
   output logic             rsp_dropped,
   input  wire logic        csr_we,
   input  wire logic [9:0]  csr_wdata
);
   import ctpp_pkg::*;

   // request register
   logic        s1_valid_ff;
   logic        s1_valid_in;
   cmd_type     s1_cmd_ff;
   logic [7:0]  s1_byte_ff;
   logic [15:0] s1_elapsed_ff;

   // response register
   logic        out_valid_ff;
   logic        out_valid_in;
   logic        out_level_ff;
   logic        out_starved_ff;
   logic        out_dropped_ff;

   logic          advance;
   logic          take;
   logic          res_level;
   logic          res_starved;
   logic          res_dropped;
   fifo_ctl_type  fifo_ctl;
   fifo_stat_type fifo_stat;
   head_type      fifo_head;

   // Advance the held request whenever the response slot is free or draining
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign s1_valid_in  = take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request payload on acceptance
   always_ff @(posedge clock) begin
      if (take) begin
         s1_cmd_ff     <= req_cmd;
         s1_byte_ff    <= req_tape_byte;
         s1_elapsed_ff <= req_cycles_elapsed;
      end
   end

   // Load the response as the request resolves; hold it while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         out_level_ff   <= res_level;
         out_starved_ff <= res_starved;
         out_dropped_ff <= res_dropped;
      end
   end

   ctpp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .ctl   (fifo_ctl),
      .stat  (fifo_stat),
      .head  (fifo_head)
   );

   ctpp_player u_player (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .cmd            (s1_cmd_ff),
      .tape_byte      (s1_byte_ff),
      .cycles_elapsed (s1_elapsed_ff),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .stat           (fifo_stat),
      .head           (fifo_head),
      .ctl            (fifo_ctl),
      .level          (res_level),
      .starved        (res_starved),
      .dropped        (res_dropped)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_level   = out_level_ff;
   assign rsp_starved = out_starved_ff;
   assign rsp_dropped = out_dropped_ff;

endmodule

`default_nettype wire

>>> rtl/core/ctpp_fifo.sv
// Shifting byte FIFO with a four-byte head window for the tape pulse player.
// Depends on ctpp_pkg.
`default_nettype none

module ctpp_fifo #(
   parameter int DEPTH = ctpp_pkg::FIFO_DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctpp_pkg::fifo_ctl_type ctl,
   output ctpp_pkg::fifo_stat_type     stat,
   output ctpp_pkg::head_type          head
);
   import ctpp_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [7:0]    mem_ff [DEPTH];
   logic [7:0]    ext    [DEPTH + HEAD_BYTES];
   logic [7:0]    mem_in [DEPTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // Pad the tail so the shift window never leaves the array
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ext[i] = mem_ff[i];
      end
      for (int i = DEPTH; i < DEPTH + HEAD_BYTES; i++) begin
         ext[i] = 8'd0;
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         case (ctl.pop_cnt)
            3'd1:    mem_in[i] = ext[i + 1];
            3'd2:    mem_in[i] = ext[i + 2];
            3'd3:    mem_in[i] = ext[i + 3];
            3'd4:    mem_in[i] = ext[i + 4];
            default: mem_in[i] = ext[i];
         endcase
         if (ctl.push && (count_ff == CW'(i))) begin
            mem_in[i] = ctl.wdata;
         end
      end
   end

   always_comb begin
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.push) begin
         count_in = count_ff + CW'(1);
      end else begin
         count_in = count_ff - CW'(ctl.pop_cnt);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         mem_ff[i] <= mem_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      for (int j = 0; j < HEAD_BYTES; j++) begin
         head[j]       = mem_ff[j];
         stat.avail[j] = (count_ff >= CW'(j + 1));
      end
      stat.full = (count_ff == CW'(DEPTH));
   end

endmodule

`default_nettype wire

>>> rtl/core/ctpp_player.sv
// Pulse state and per-request decode for the tape pulse player.
// Depends on ctpp_pkg; drives the ctpp_fifo control struct.
`default_nettype none

module ctpp_player (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire ctpp_pkg::cmd_type       cmd,
   input  wire logic [7:0]              tape_byte,
   input  wire logic [15:0]             cycles_elapsed,
   input  wire logic                    csr_we,
   input  wire logic [9:0]              csr_wdata,
   input  wire ctpp_pkg::fifo_stat_type stat,
   input  wire ctpp_pkg::head_type      head,
   output ctpp_pkg::fifo_ctl_type       ctl,
   output logic                         level,
   output logic                         starved,
   output logic                         dropped
);
   import ctpp_pkg::*;

   logic [9:0]  cps_ff;
   logic        first_ff,  first_in;
   logic        tlevel_ff, tlevel_in;
   logic [15:0] pulse_ff,  pulse_in;
   logic [15:0] acc_ff,    acc_in;

   logic [16:0] sum;
   logic        ok;
   logic        off;
   logic [1:0]  lo_idx;
   logic [1:0]  hi_idx;
   logic [7:0]  code;
   fifo_ctl_type ctl_v;

   always_comb begin
      first_in  = first_ff;
      tlevel_in = tlevel_ff;
      pulse_in  = pulse_ff;
      acc_in    = acc_ff;
      ctl_v     = '{clear: 1'b0, push: 1'b0, pop_cnt: 3'd0, wdata: tape_byte};
      ok        = 1'b1;
      off       = 1'b0;
      sum       = {1'b0, acc_ff} + {1'b0, cycles_elapsed};
      lo_idx    = 2'd1;
      hi_idx    = 2'd2;
      code      = head[0];
      level     = tlevel_ff;
      dropped   = 1'b0;

      case (cmd)
         CMD_RESTART: begin
            first_in    = 1'b1;
            ctl_v.clear = 1'b1;
         end
         CMD_PUSH: begin
            if (stat.full) begin
               dropped = 1'b1;
            end else begin
               ctl_v.push = 1'b1;
            end
         end
         CMD_READ: begin
            acc_in = sum[16] ? 16'hFFFF : sum[15:0];
            // first read after restart: polarity byte
            if (first_ff) begin
               pulse_in = '0;
               first_in = 1'b0;
               if (!stat.avail[0]) begin
                  ok = 1'b0;
               end else begin
                  acc_in    = '0;
                  tlevel_in = (head[0] > LEVEL_THRESHOLD);
                  off       = 1'b1;
               end
            end
            lo_idx = {1'b0, off} + 2'd1;
            hi_idx = {1'b0, off} + 2'd2;
            code   = off ? head[1] : head[0];
            // pulse ran out: toggle and fetch the next length
            if (ok && (pulse_in == '0)) begin
               tlevel_in     = ~tlevel_in;
               ctl_v.pop_cnt = {2'b0, off};
               if (!stat.avail[off]) begin
                  ok = 1'b0;
               end else if (code != 8'd0) begin
                  pulse_in      = {8'd0, code};
                  ctl_v.pop_cnt = {2'b0, off} + 3'd1;
               end else if (!stat.avail[lo_idx]) begin
                  ok            = 1'b0;
                  ctl_v.pop_cnt = {2'b0, off} + 3'd1;
               end else if (!stat.avail[hi_idx]) begin
                  ok            = 1'b0;
                  ctl_v.pop_cnt = {2'b0, off} + 3'd2;
               end else begin
                  pulse_in      = {head[hi_idx], head[lo_idx]};
                  ctl_v.pop_cnt = {2'b0, off} + 3'd3;
               end
            end else if (ok) begin
               ctl_v.pop_cnt = {2'b0, off};
            end else begin
               ctl_v.pop_cnt = 3'd0;
            end
            // one sample period elapsed: advance the pulse
            if (ok && (acc_in >= {6'd0, cps_ff})) begin
               if (acc_in >= {5'd0, cps_ff, 1'b0}) begin
                  acc_in = '0;
               end else begin
                  acc_in = acc_in - {6'd0, cps_ff};
               end
               if (pulse_in != '0) begin
                  pulse_in = pulse_in - 16'd1;
               end
            end
            level = ok ? tlevel_in : 1'b1;
         end
         default: begin
         end
      endcase

      starved = ~ok;
      ctl     = ctl_v;
      if (!fire) begin
         ctl.clear   = 1'b0;
         ctl.push    = 1'b0;
         ctl.pop_cnt = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cps_ff    <= CPS_RESET;
         first_ff  <= 1'b1;
         tlevel_ff <= 1'b0;
         pulse_ff  <= '0;
         acc_ff    <= '0;
      end else begin
         if (csr_we) begin
            cps_ff <= csr_wdata;
         end
         if (fire) begin
            first_ff  <= first_in;
            tlevel_ff <= tlevel_in;
            pulse_ff  <= pulse_in;
            acc_ff    <= acc_in;
         end
      end
   end

endmodule

`default_nettype wire
